// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked on clk and disabled while rst is high in the scope of the user.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check the consequent in the same cycle as the antecedent
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check the consequent in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/sptp_pkg.sv
// ---------------------------------------------------------------------------
// sptp_pkg
// Shared widths, register indexes, option bits, controller states and the
// command and status words between controller and datapath.
// ---------------------------------------------------------------------------
package sptp_pkg;

  // Field widths
  localparam int POS_BITS       = 21;
  localparam int TRIM_BITS      = 11;
  localparam int OPT_BITS       = 5;
  localparam int OUT_BITS       = 16;
  localparam int END_BITS       = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 21;

  // Datapath widths: scaled end pulse, span, products, dividend, divisor
  localparam int SCALE_BITS = 27;
  localparam int SPAN_BITS  = 21;
  localparam int PROD_BITS  = SCALE_BITS + SPAN_BITS;
  localparam int NUM_BITS   = PROD_BITS + 1;
  localparam int DEN_BITS   = 31;
  localparam int QUOT_BITS  = 17;
  localparam int DSH_BITS   = DEN_BITS + QUOT_BITS - 1;
  localparam int DIV_COUNT_BITS = $clog2(QUOT_BITS);

  // Trims are in thousandths of full scale
  localparam int FULL_SCALE = 1000;
  localparam int TRIM_SPAN  = 2000;

  // Register reset values
  localparam int POS_LOW_RESET  = 0;
  localparam int POS_HIGH_RESET = 5000;
  localparam int HOMING_RESET   = 0;
  localparam int TRIM_RESET     = 1000;
  localparam int OPT_RESET      = 4;

  // Option bit positions
  localparam int OPT_INVERT        = 0;
  localparam int OPT_HOMING_TARGET = 1;
  localparam int OPT_MACHINE_POS   = 2;
  localparam int OPT_ALARM_OFF     = 3;
  localparam int OPT_STEPPER_OFF   = 4;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_POSITION_LOW  = 3'd0,
    REG_POSITION_HIGH = 3'd1,
    REG_HOMING_TARGET = 3'd2,
    REG_LOW_END_TRIM  = 3'd3,
    REG_HIGH_END_TRIM = 3'd4,
    REG_OPTION_BITS   = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE_A,
    ST_SCALE_B,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic scale_a;
    logic scale_b;
    logic mul_lo;
    logic mul_hi;
    logic sum;
    logic div_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic forced_off;
    logic out_free;
  } status_t;

endpackage

// File: rtl/sptp_ctrl.sv
// ---------------------------------------------------------------------------
// sptp_ctrl
// Sequencer: walks one word through scaling, two products, the sum and the
// divider (forced-off words skip to the end), then feeds the output register.
// ---------------------------------------------------------------------------
module sptp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  sptp_pkg::status_t status,
  output sptp_pkg::cmd_t    cmd
);
  import sptp_pkg::*;

  localparam logic [DIV_COUNT_BITS-1:0] DIV_LAST = DIV_COUNT_BITS'(QUOT_BITS - 1);

  state_t                    state;
  state_t                    state_next;
  logic [DIV_COUNT_BITS-1:0] div_count;
  logic [DIV_COUNT_BITS-1:0] div_count_next;

  // Advance state and divider step count
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      div_count <= '0;
    end else begin
      state     <= state_next;
      div_count <= div_count_next;
    end
  end

  // Next state
  always_comb begin
    state_next     = state;
    div_count_next = div_count;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SCALE_A;
      end
      ST_SCALE_A: begin
        state_next = status.forced_off ? ST_DONE : ST_SCALE_B;
      end
      ST_SCALE_B: state_next = ST_MUL_LO;
      ST_MUL_LO:  state_next = ST_MUL_HI;
      ST_MUL_HI:  state_next = ST_SUM;
      ST_SUM: begin
        state_next     = ST_DIV;
        div_count_next = DIV_LAST;
      end
      ST_DIV: begin
        if (div_count == '0) begin
          state_next = ST_DONE;
        end else begin
          div_count_next = div_count - 1'b1;
        end
      end
      ST_DONE: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_SCALE_A: cmd.scale_a  = 1'b1;
      ST_SCALE_B: cmd.scale_b  = 1'b1;
      ST_MUL_LO:  cmd.mul_lo   = 1'b1;
      ST_MUL_HI:  cmd.mul_hi   = 1'b1;
      ST_SUM:     cmd.sum      = 1'b1;
      ST_DIV:     cmd.div_step = 1'b1;
      ST_DONE:    cmd.emit     = status.out_free;
      default:    cmd          = '0;
    endcase
  end

endmodule

// File: rtl/sptp_datapath.sv
// ---------------------------------------------------------------------------
// sptp_datapath
// Configuration registers, position select and clamp, one shared multiplier,
// a restoring divider and the output register.
// ---------------------------------------------------------------------------
module sptp_datapath #(
  parameter int unsigned PULSE_BITS     = 16,
  parameter int unsigned LOW_END_PULSE  = 3277,
  parameter int unsigned HIGH_END_PULSE = 6554,
  parameter int unsigned TRIM_FLOOR     = 200,
  parameter int unsigned TRIM_CEILING   = 1800
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  sptp_pkg::cmd_t                        cmd,
  output sptp_pkg::status_t                     status,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [sptp_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [sptp_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic signed [sptp_pkg::POS_BITS-1:0]  machine_position,
  input  logic signed [sptp_pkg::POS_BITS-1:0]  work_offset,
  input  logic                                  alarm_active,
  input  logic                                  homing_active,
  input  logic                                  steppers_off,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [sptp_pkg::OUT_BITS-1:0]         pulse_length,
  output logic                                  write_strobe,
  output logic                                  trim_fault
);
  import sptp_pkg::*;

  localparam int unsigned PULSE_MAX =
    (PULSE_BITS >= OUT_BITS) ? (1 << OUT_BITS) - 1 : (1 << PULSE_BITS) - 1;
  localparam int EXT_BITS = POS_BITS + 1;

  // Configuration registers
  logic signed [POS_BITS-1:0] position_low;
  logic signed [POS_BITS-1:0] position_high;
  logic signed [POS_BITS-1:0] homing_target;
  logic [TRIM_BITS-1:0]       low_end_trim;
  logic [TRIM_BITS-1:0]       high_end_trim;
  logic [OPT_BITS-1:0]        option_bits;

  // Per-word registers
  logic signed [EXT_BITS-1:0] pos;
  logic                       forced_off;
  logic                       fault;
  logic signed [EXT_BITS-1:0] x_clamp;
  logic                       range_ok;
  logic [DEN_BITS-1:0]        den;
  logic [SCALE_BITS-1:0]      a_scaled;
  logic [SCALE_BITS-1:0]      b_scaled;
  logic [SPAN_BITS-1:0]       span_hi;
  logic [SPAN_BITS-1:0]       span_lo;
  logic [PROD_BITS-1:0]       acc_lo;
  logic [PROD_BITS-1:0]       acc_hi;
  logic [NUM_BITS-1:0]        rem;
  logic [DSH_BITS-1:0]        dsh;
  logic [QUOT_BITS-1:0]       quot;
  logic [OUT_BITS-1:0]        last_pulse;

  // Combinational helpers
  logic signed [EXT_BITS-1:0] pos_sel;
  logic                       forced_sel;
  logic                       trims_ok;
  logic                       inv;
  logic [TRIM_BITS-1:0]       factor_a;
  logic [TRIM_BITS-1:0]       factor_b;
  logic [END_BITS-1:0]        end_lo;
  logic [END_BITS-1:0]        end_hi;
  logic signed [EXT_BITS-1:0] low_ext;
  logic signed [EXT_BITS-1:0] high_ext;
  logic signed [EXT_BITS-1:0] d;
  logic                       range_pos;
  logic signed [EXT_BITS-1:0] x_sel;
  logic [DEN_BITS-1:0]        den_sel;
  logic [SCALE_BITS-1:0]      mul_x;
  logic [SPAN_BITS-1:0]       mul_y;
  logic [PROD_BITS-1:0]       prod;
  logic                       fits;
  logic [OUT_BITS-1:0]        pulse_sat;
  logic [OUT_BITS-1:0]        pulse_fin;

  assign cfg_ready = 1'b1;

  // Register writes; unknown indexes drop the word
  always_ff @(posedge clk) begin
    if (rst) begin
      position_low  <= POS_BITS'(POS_LOW_RESET);
      position_high <= POS_BITS'(POS_HIGH_RESET);
      homing_target <= POS_BITS'(HOMING_RESET);
      low_end_trim  <= TRIM_BITS'(TRIM_RESET);
      high_end_trim <= TRIM_BITS'(TRIM_RESET);
      option_bits   <= OPT_BITS'(OPT_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_POSITION_LOW:  position_low  <= cfg_data[POS_BITS-1:0];
        REG_POSITION_HIGH: position_high <= cfg_data[POS_BITS-1:0];
        REG_HOMING_TARGET: homing_target <= cfg_data[POS_BITS-1:0];
        REG_LOW_END_TRIM:  low_end_trim  <= cfg_data[TRIM_BITS-1:0];
        REG_HIGH_END_TRIM: high_end_trim <= cfg_data[TRIM_BITS-1:0];
        REG_OPTION_BITS:   option_bits   <= cfg_data[OPT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Pick the commanded position and the disable condition
  always_comb begin
    if (option_bits[OPT_HOMING_TARGET] && homing_active) begin
      pos_sel = EXT_BITS'(homing_target);
    end else if (option_bits[OPT_MACHINE_POS]) begin
      pos_sel = EXT_BITS'(machine_position);
    end else begin
      pos_sel = EXT_BITS'(machine_position) - EXT_BITS'(work_offset);
    end
    forced_sel = (option_bits[OPT_ALARM_OFF] && alarm_active) ||
                 (option_bits[OPT_STEPPER_OFF] && steppers_off);
  end

  // Trim factors in thousandths; out-of-limit trims fall back to full scale
  always_comb begin
    inv      = option_bits[OPT_INVERT];
    trims_ok = (low_end_trim >= TRIM_BITS'(TRIM_FLOOR)) &&
               (low_end_trim <= TRIM_BITS'(TRIM_CEILING)) &&
               (high_end_trim >= TRIM_BITS'(TRIM_FLOOR)) &&
               (high_end_trim <= TRIM_BITS'(TRIM_CEILING));
    if (!trims_ok) begin
      factor_a = TRIM_BITS'(FULL_SCALE);
      factor_b = TRIM_BITS'(FULL_SCALE);
    end else if (inv) begin
      factor_a = low_end_trim;
      factor_b = TRIM_BITS'(TRIM_SPAN) - high_end_trim;
    end else begin
      factor_a = TRIM_BITS'(TRIM_SPAN) - low_end_trim;
      factor_b = high_end_trim;
    end
    end_lo = inv ? END_BITS'(HIGH_END_PULSE) : END_BITS'(LOW_END_PULSE);
    end_hi = inv ? END_BITS'(LOW_END_PULSE) : END_BITS'(HIGH_END_PULSE);
  end

  // Range, clamp and divisor
  always_comb begin
    low_ext   = EXT_BITS'(position_low);
    high_ext  = EXT_BITS'(position_high);
    d         = high_ext - low_ext;
    range_pos = d > 0;
    if (pos < low_ext) begin
      x_sel = low_ext;
    end else if (pos > high_ext) begin
      x_sel = high_ext;
    end else begin
      x_sel = pos;
    end
    den_sel = range_pos ? DEN_BITS'(d[SPAN_BITS-1:0]) * DEN_BITS'(FULL_SCALE)
                        : DEN_BITS'(FULL_SCALE);
  end

  // Shared multiplier operands
  always_comb begin
    mul_x = a_scaled;
    mul_y = span_hi;
    if (cmd.scale_a) begin
      mul_x = SCALE_BITS'(end_lo);
      mul_y = SPAN_BITS'(factor_a);
    end else if (cmd.scale_b) begin
      mul_x = SCALE_BITS'(end_hi);
      mul_y = SPAN_BITS'(factor_b);
    end else if (cmd.mul_hi) begin
      mul_x = b_scaled;
      mul_y = span_lo;
    end
    prod = PROD_BITS'(mul_x) * PROD_BITS'(mul_y);
  end

  assign fits      = rem >= NUM_BITS'(dsh);
  assign pulse_sat = (quot > QUOT_BITS'(PULSE_MAX)) ? OUT_BITS'(PULSE_MAX)
                                                    : quot[OUT_BITS-1:0];
  assign pulse_fin = forced_off ? '0 : pulse_sat;

  // Capture the word, then scale, multiply, sum and divide
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pos        <= pos_sel;
      forced_off <= forced_sel;
      fault      <= !trims_ok;
    end
    if (cmd.scale_a) begin
      a_scaled <= prod[SCALE_BITS-1:0];
      x_clamp  <= x_sel;
      range_ok <= range_pos;
      den      <= den_sel;
    end
    if (cmd.scale_b) begin
      b_scaled <= prod[SCALE_BITS-1:0];
      span_hi  <= SPAN_BITS'(high_ext - x_clamp);
      span_lo  <= SPAN_BITS'(x_clamp - low_ext);
    end
    if (cmd.mul_lo) acc_lo <= prod;
    if (cmd.mul_hi) acc_hi <= prod;
    if (cmd.sum) begin
      rem  <= range_ok ? NUM_BITS'(acc_lo) + NUM_BITS'(acc_hi) : NUM_BITS'(a_scaled);
      dsh  <= {den, (QUOT_BITS-1)'(0)};
      quot <= '0;
    end
    if (cmd.div_step) begin
      if (fits) rem <= rem - NUM_BITS'(dsh);
      quot <= {quot[QUOT_BITS-2:0], fits};
      dsh  <= dsh >> 1;
    end
  end

  // Output register and last pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      last_pulse <= '0;
    end else if (cmd.emit) begin
      out_valid  <= 1'b1;
      last_pulse <= pulse_fin;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pulse_length <= pulse_fin;
      write_strobe <= pulse_fin != last_pulse;
      trim_fault   <= fault && !forced_off;
    end
  end

  assign status.forced_off = forced_off;
  assign status.out_free   = !out_valid || !out_stall;

endmodule

// File: rtl/servo_position_to_pulse.sv
// Servo position to pulse: one input word (position, offset, machine flags)
// gives one output word holding the servo duty count, a write strobe when the
// count changes and a trim fault flag. Input stalls while a word goes through
// scaling, two products, the sum and the 17-step restoring divider behind the
// shared multiplier; a word forced off by alarm or stepper disable goes from
// scaling to the output. The result waits in an output register, so the next
// word is accepted while it is stalled. Write configuration only while idle.
// ---------------------------------------------------------------------------
// servo_position_to_pulse
// Top level: joins the sequencer and the datapath.
// ---------------------------------------------------------------------------
module servo_position_to_pulse #(
  parameter int unsigned PULSE_BITS     = 16,
  parameter int unsigned LOW_END_PULSE  = 3277,
  parameter int unsigned HIGH_END_PULSE = 6554,
  parameter int unsigned TRIM_FLOOR     = 200,
  parameter int unsigned TRIM_CEILING   = 1800
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [sptp_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [sptp_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [sptp_pkg::POS_BITS-1:0]  machine_position,
  input  logic signed [sptp_pkg::POS_BITS-1:0]  work_offset,
  input  logic                                  alarm_active,
  input  logic                                  homing_active,
  input  logic                                  steppers_off,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [sptp_pkg::OUT_BITS-1:0]         pulse_length,
  output logic                                  write_strobe,
  output logic                                  trim_fault
);
  import sptp_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer
  sptp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath
  sptp_datapath #(
    .PULSE_BITS     (PULSE_BITS),
    .LOW_END_PULSE  (LOW_END_PULSE),
    .HIGH_END_PULSE (HIGH_END_PULSE),
    .TRIM_FLOOR     (TRIM_FLOOR),
    .TRIM_CEILING   (TRIM_CEILING)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .machine_position (machine_position),
    .work_offset      (work_offset),
    .alarm_active     (alarm_active),
    .homing_active    (homing_active),
    .steppers_off     (steppers_off),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .pulse_length     (pulse_length),
    .write_strobe     (write_strobe),
    .trim_fault       (trim_fault)
  );

endmodule

// File: rtl/sptp_checker.sv
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// sptp_checker
// Port-level checks on the servo pulse block, bound to the top level.
// ---------------------------------------------------------------------------
module sptp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] pulse_length,
  input logic        write_strobe,
  input logic        trim_fault
);

  logic [15:0] last_seen;

  // Track the pulse of the last delivered word
  always_ff @(posedge clk) begin
    if (rst) begin
      last_seen <= '0;
    end else if (out_valid && !out_stall) begin
      last_seen <= pulse_length;
    end
  end

  // A word in work blocks the next one
  `ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // Strobe marks a change against the previous delivered pulse
  `ASSERT_SAME(a_strobe_on_change, out_valid && !out_stall, write_strobe == (pulse_length != last_seen))

  // A trim fault only comes with a live, nonzero pulse
  `ASSERT_SAME(a_fault_has_pulse, out_valid && trim_fault, pulse_length != 16'd0)

  // Stalled result holds
  `ASSERT_NEXT(a_stalled_holds, out_valid && out_stall, out_valid && $stable(pulse_length))

endmodule

bind servo_position_to_pulse sptp_checker u_checker (.*);
